// ===== design/rip_pkg.sv =====
package rip_pkg;

	localparam int CfgAw = 4;

	typedef logic [1:0]  phase_t;
	typedef logic [16:0] gap_t;

	localparam phase_t PH_WAIT = 2'd0;
	localparam phase_t PH_RUN  = 2'd1;
	localparam phase_t PH_HALT = 2'd2;

	localparam logic [1:0] RP_WARMUP  = 2'd0;
	localparam logic [1:0] RP_RUNNING = 2'd1;

	localparam logic [1:0] REG_ENABLE  = 2'd0;
	localparam logic [1:0] REG_SEED    = 2'd1;
	localparam logic [1:0] REG_GAP_MIN = 2'd2;
	localparam logic [1:0] REG_GAP_MAX = 2'd3;

	localparam int XsA = 13;
	localparam int XsB = 17;
	localparam int XsC = 5;

	function automatic logic [31:0] xs_next(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x << XsA);
		y = y ^ (y >> XsB);
		y = y ^ (y << XsC);
		return y;
	endfunction

endpackage

// ===== design/rip_if.sv =====
interface rip_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] run_phase;

	modport source (output valid, output run_phase, input ready);
	modport sink   (input valid, input run_phase, output ready);
endinterface

interface rip_out_if;
	logic        valid;
	logic        ready;
	logic        press;
	logic [31:0] press_count;
	logic        halted;

	modport source (output valid, output press, output press_count, output halted, input ready);
	modport sink   (input valid, input press, input press_count, input halted, output ready);
endinterface

// ===== design/random_interval_press_injector_unit.sv =====
// Random-interval press injector.
// in_ch carries one word per millisecond tick holding run_phase; out_ch returns
// one word per tick: press, the running press_count and halted.
// Registers sit on an APB port: enable at 0x0, seed at 0x4, gap_min at 0x8 and
// gap_max at 0xC; pready is tied high, writes land on the access cycle.
// A tick that needs no new gap passes through ST_OUT and is loaded into the
// output register once that register is free. A tick that draws a gap (the first
// running tick and every press) first runs a bit-serial modulo in ST_DIV, one
// dividend bit a cycle over all 32 bits, then passes through ST_OUT the same way.
// in_ch.ready is low from a taken tick until its result is in the output
// register, so no new tick is taken before the last one is placed.
// The output register parts the channels: a new tick is taken while a result
// waits; if out_ch stalls, the next result is held back in the sequencer and
// in_ch.ready stays low until the output register frees.
// Reset clears all registers and state: waiting phase, zero count, disabled.
module random_interval_press_injector_unit
	import rip_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	rip_in_if.sink              in_ch,
	rip_out_if.source           out_ch,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CfgAw-1:0]    paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic        enable_q;
	logic [31:0] seed_q;
	logic [15:0] gap_min_q;
	logic [15:0] gap_max_q;

	logic [31:0] rng_q;
	gap_t        remaining_q;
	phase_t      phase_q;
	logic [31:0] injected_q;
	logic        press_q;

	logic [1:0]  st_q;
	logic [31:0] div_q;
	gap_t        rem_q;
	logic [4:0]  cnt_q;

	logic        ovalid_q;
	logic        opress_q;
	logic [31:0] ocount_q;
	logic        ohalt_q;

	logic [15:0] hi;
	gap_t        span;
	logic [17:0] trial;
	logic        ge;
	gap_t        rem_nx;
	gap_t        gap_sum;
	gap_t        gap_fin;
	gap_t        rem_dec;
	logic        accept;
	logic        cfg_wr;
	logic        out_free;
	logic [1:0]  rp;
	logic [31:0] draw_base;
	logic [31:0] draw_x;
	logic        press_nx;
	logic        go_div;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign rp       = in_ch.run_phase;
	assign in_ch.ready = (st_q == ST_IDLE);
	assign accept   = in_ch.valid && in_ch.ready;
	assign out_free = !ovalid_q || out_ch.ready;

	assign hi      = (gap_max_q < gap_min_q) ? gap_min_q : gap_max_q;
	assign span    = {1'b0, hi} - {1'b0, gap_min_q} + 17'd1;
	assign trial   = {rem_q, div_q[31]};
	assign ge      = trial >= {1'b0, span};
	assign rem_nx  = ge ? 17'(trial - {1'b0, span}) : trial[16:0];
	assign gap_sum = {1'b0, gap_min_q} + rem_nx;
	assign gap_fin = (gap_sum == '0) ? 17'd1 : gap_sum;
	assign rem_dec = (remaining_q == '0) ? '0 : remaining_q - 17'd1;

	assign draw_base = (phase_q == PH_WAIT) ? (seed_q | 32'd1) : rng_q;
	assign draw_x    = xs_next(draw_base);

	assign press_nx = enable_q && (phase_q == PH_RUN) && (rp == RP_RUNNING)
		&& (rem_dec == '0);
	assign go_div   = press_nx || (enable_q && (phase_q == PH_WAIT) && (rp == RP_RUNNING));

	assign out_ch.valid       = ovalid_q;
	assign out_ch.press       = opress_q;
	assign out_ch.press_count = ocount_q;
	assign out_ch.halted      = ohalt_q;

	always_comb begin
		case (paddr[3:2])
			REG_ENABLE:  prdata = {31'd0, enable_q};
			REG_SEED:    prdata = seed_q;
			REG_GAP_MIN: prdata = {16'd0, gap_min_q};
			REG_GAP_MAX: prdata = {16'd0, gap_max_q};
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			seed_q    <= '0;
			gap_min_q <= '0;
			gap_max_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_ENABLE:  enable_q  <= pwdata[0];
				REG_SEED:    seed_q    <= pwdata;
				REG_GAP_MIN: gap_min_q <= pwdata[15:0];
				REG_GAP_MAX: gap_max_q <= pwdata[15:0];
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rng_q       <= '0;
			remaining_q <= '0;
			phase_q     <= PH_WAIT;
			injected_q  <= '0;
			press_q     <= 1'b0;
			st_q        <= ST_IDLE;
			div_q       <= '0;
			rem_q       <= '0;
			cnt_q       <= '0;
			ovalid_q    <= 1'b0;
			opress_q    <= 1'b0;
			ocount_q    <= '0;
			ohalt_q     <= 1'b0;
		end else begin
			if (ovalid_q && out_ch.ready && st_q != ST_OUT)
				ovalid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						press_q <= press_nx;
						st_q    <= go_div ? ST_DIV : ST_OUT;
						if (enable_q) begin
							if (phase_q == PH_WAIT) begin
								if (rp == RP_RUNNING) begin
									phase_q <= PH_RUN;
									rng_q   <= draw_x;
									div_q   <= draw_x;
									rem_q   <= '0;
									cnt_q   <= '0;
								end else if (rp != RP_WARMUP) begin
									phase_q <= PH_HALT;
								end
							end else if (phase_q == PH_RUN) begin
								if (rp != RP_RUNNING) begin
									phase_q     <= PH_HALT;
									remaining_q <= '0;
								end else begin
									remaining_q <= rem_dec;
									if (rem_dec == '0) begin
										injected_q <= injected_q + 32'd1;
										rng_q      <= draw_x;
										div_q      <= draw_x;
										rem_q      <= '0;
										cnt_q      <= '0;
									end
								end
							end
						end
					end
				end
				ST_DIV: begin
					rem_q <= rem_nx;
					div_q <= {div_q[30:0], 1'b0};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						remaining_q <= gap_fin;
						st_q        <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						opress_q <= press_q;
						ocount_q <= injected_q;
						ohalt_q  <= (phase_q == PH_HALT);
						st_q     <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALT |=> phase_q == PH_HALT)
		else $error("halted phase left");

	a_rem_below_span: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DIV |-> rem_q < span)
		else $error("partial remainder not below span");

	a_gap_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV && cnt_q == 5'd31) |=> remaining_q != '0)
		else $error("drawn gap is zero");

	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_OUT && out_free) |=> (ovalid_q && st_q == ST_IDLE))
		else $error("result not loaded into output register");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ch.ready)
		else $error("new word taken before result was placed");

endmodule
